// File: rtl/assert_macros.svh
// assertion macros shared by the pulse beat detector rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PBD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pbd assertion failed");
`define PBD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pbd implication failed");
`else
`define PBD_ASSERT(label, clk, rst, prop)
`define PBD_ASSERT_IMP(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/pbd_pkg.sv
// types and constants of the pulse beat detector
// no dependencies; used by pbd_div and pulse_beat_detector
package pbd_pkg;

   localparam int unsigned DIV_W     = 11;  // divisor width, covers intervals below 2048
   localparam int unsigned QUO_W     = 8;   // quotient width, rate stays below 256
   localparam int unsigned DIV_STEPS = 16;  // one quotient bit per cycle over the dividend
   localparam int unsigned CNT_W     = 4;

   localparam logic [DIV_STEPS-1:0] MS_PER_MIN   = 16'd60000;
   localparam logic [31:0]          BEAT_MIN_IBI = 32'd300;
   localparam logic [31:0]          BEAT_MAX_IBI = 32'd2000;
   localparam logic [31:0]          WINDOW_MS    = 32'd2000;

   localparam logic signed [15:0] BASELINE_RESET = 16'sd2048;
   localparam logic signed [15:0] PEAK_MAX_RESET = 16'sd0;
   localparam logic signed [15:0] PEAK_MIN_RESET = 16'sd32767;

   typedef struct packed {
      logic signed [15:0] sample;
      logic [31:0]        now_ms;
   } req_type;

   typedef struct packed {
      logic [7:0]         bpm;
      logic               beat_detected;
      logic signed [15:0] threshold;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// File: rtl/pbd_div.sv
// restoring divider: 60000 / interval, one quotient bit per cycle
// depends on pbd_pkg
module pbd_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [pbd_pkg::DIV_W-1:0]       divisor,
   output pbd_pkg::div_status_type         status,
   output logic [pbd_pkg::QUO_W-1:0]       quotient
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [pbd_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [pbd_pkg::DIV_W-1:0]     dvs_ff, dvs_in;
   logic [pbd_pkg::DIV_W-1:0]     rem_ff, rem_in;
   logic [pbd_pkg::QUO_W-1:0]     quo_ff, quo_in;
   logic [pbd_pkg::DIV_W:0]       trial;
   logic                          fits;

   // shift in the next dividend bit, msb first
   assign trial = {rem_ff, pbd_pkg::MS_PER_MIN[cnt_ff]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = pbd_pkg::CNT_W'(pbd_pkg::DIV_STEPS - 1);
         dvs_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? pbd_pkg::DIV_W'(trial - {1'b0, dvs_ff})
                       : pbd_pkg::DIV_W'(trial);
         quo_in = {quo_ff[pbd_pkg::QUO_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// File: rtl/pulse_beat_detector.sv
// pulse beat detector top level: sequencer, detector state and output register
// depends on pbd_pkg, pbd_div and assert_macros.svh

// One request carries a signed sample and a millisecond timestamp and yields
// exactly one response with the current bpm, the beat flag and the midpoint
// threshold that was used for that sample. The block takes one request at a
// time and stalls its input meanwhile: a request without a qualifying beat
// interval passes through the peak, threshold and decide steps to the output
// step, which loads the response register, and the next request can be taken
// once the block is back in idle. One that updates bpm also passes through
// the divide step, where the bit-serial divider forms 60000 / interval one
// quotient bit per cycle, and the quotient is then handed over to bpm before
// the output step. A finished response waits in its own register,
// so the next request may be taken while the previous response is still
// stalled; the following response then holds in the output step until the
// first one is taken. The baseline is written through csr_wr_en /
// csr_wr_data and takes effect at the next window reset; write it only while
// the block is idle.
`include "assert_macros.svh"

module pulse_beat_detector (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  pbd_pkg::req_type   req_data,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output pbd_pkg::rsp_type   rsp_data,
   // configuration
   input  logic               csr_wr_en,
   input  logic signed [15:0] csr_wr_data
);

   // sequencer codes
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PEAK   = 3'd1;
   localparam logic [2:0] S_THR    = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_DIV    = 3'd4;
   localparam logic [2:0] S_OUT    = 3'd5;

   logic [2:0]                state_ff, state_in;

   // latched request
   logic signed [15:0]        sample_ff, sample_in;
   logic [31:0]               now_ff, now_in;

   // detector state
   logic signed [15:0]        baseline_ff, baseline_in;
   logic signed [15:0]        max_ff, max_in;
   logic signed [15:0]        min_ff, min_in;
   logic                      flag_ff, flag_in;
   logic [31:0]               last_beat_ff, last_beat_in;
   logic [31:0]               last_reset_ff, last_reset_in;
   logic [7:0]                bpm_ff, bpm_in;

   // per-request intermediates
   logic signed [15:0]        thr_ff, thr_in;
   logic                      in_band_ff, in_band_in;
   logic                      win_ff, win_in;
   logic [pbd_pkg::DIV_W-1:0] ibi_ff, ibi_in;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   pbd_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   logic [31:0]               ibi;
   logic [31:0]               since_reset;
   logic signed [16:0]        span;
   logic signed [16:0]        thr_sum;
   logic                      beat;
   logic                      out_free;
   logic                      div_start;
   pbd_pkg::div_status_type   div_status;
   logic [pbd_pkg::QUO_W-1:0] div_quo;

   // modular time differences, evaluated once the request is latched
   assign ibi         = now_ff - last_beat_ff;
   assign since_reset = now_ff - last_reset_ff;

   // max is never below min after widening, so the halving is a plain shift
   assign span    = 17'(max_ff) - 17'(min_ff);
   assign thr_sum = 17'(min_ff) + (span >>> 1);

   // rising crossing while unarmed
   assign beat = (sample_ff > thr_ff) && !flag_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign div_start = (state_ff == S_DECIDE) && beat && (last_beat_ff != '0) && in_band_ff;

   pbd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (ibi_ff),
      .status   (div_status),
      .quotient (div_quo)
   );

   always_comb begin
      state_in      = state_ff;
      sample_in     = sample_ff;
      now_in        = now_ff;
      baseline_in   = csr_wr_en ? csr_wr_data : baseline_ff;
      max_in        = max_ff;
      min_in        = min_ff;
      flag_in       = flag_ff;
      last_beat_in  = last_beat_ff;
      last_reset_in = last_reset_ff;
      bpm_in        = bpm_ff;
      thr_in        = thr_ff;
      in_band_in    = in_band_ff;
      win_in        = win_ff;
      ibi_in        = ibi_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               sample_in = req_data.sample;
               now_in    = req_data.now_ms;
               state_in  = S_PEAK;
            end
         end
         S_PEAK: begin
            // widen the window and classify both time differences
            if (sample_ff > max_ff) max_in = sample_ff;
            if (sample_ff < min_ff) min_in = sample_ff;
            in_band_in = (ibi > pbd_pkg::BEAT_MIN_IBI) && (ibi < pbd_pkg::BEAT_MAX_IBI);
            ibi_in     = ibi[pbd_pkg::DIV_W-1:0];
            win_in     = since_reset > pbd_pkg::WINDOW_MS;
            state_in   = S_THR;
         end
         S_THR: begin
            thr_in   = $signed(thr_sum[15:0]);
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (beat) begin
               last_beat_in = now_ff;
               flag_in      = 1'b1;
            end
            // re-arm below threshold; equal leaves the flag alone
            if (sample_ff < thr_ff) flag_in = 1'b0;
            // window reset applies to the next request
            if (win_ff) begin
               max_in        = baseline_ff;
               min_in        = baseline_ff;
               last_reset_in = now_ff;
            end
            state_in = div_start ? S_DIV : S_OUT;
         end
         S_DIV: begin
            if (div_status.done) begin
               bpm_in   = div_quo;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.bpm           = bpm_ff;
               rsp_data_in.beat_detected = flag_ff;
               rsp_data_in.threshold     = thr_ff;
               state_in                  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         baseline_ff   <= pbd_pkg::BASELINE_RESET;
         max_ff        <= pbd_pkg::PEAK_MAX_RESET;
         min_ff        <= pbd_pkg::PEAK_MIN_RESET;
         flag_ff       <= 1'b0;
         last_beat_ff  <= '0;
         last_reset_ff <= '0;
         bpm_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         baseline_ff   <= baseline_in;
         max_ff        <= max_in;
         min_ff        <= min_in;
         flag_ff       <= flag_in;
         last_beat_ff  <= last_beat_in;
         last_reset_ff <= last_reset_in;
         bpm_ff        <= bpm_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      now_ff      <= now_in;
      thr_ff      <= thr_in;
      in_band_ff  <= in_band_in;
      win_ff      <= win_in;
      ibi_ff      <= ibi_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // threshold always sits inside the widened window
   `PBD_ASSERT_IMP(a_thr_in_window, clock, reset, state_ff == S_DECIDE,
      (thr_ff >= min_ff) && (thr_ff <= max_ff))
   // the divider only runs while the sequencer waits on it
   `PBD_ASSERT_IMP(a_div_owned, clock, reset, div_status.busy, state_ff == S_DIV)
   // a set rate always comes from an in-band interval
   `PBD_ASSERT_IMP(a_bpm_range, clock, reset, bpm_ff != '0,
      (bpm_ff >= 8'd30) && (bpm_ff <= 8'd199))
   // a new response only appears from the output step
   `PBD_ASSERT(a_rsp_source, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)

endmodule
